// ===== sv/scfr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the sync command frame receiver.
package scfr_pkg;

   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;
   localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h55;

   // register index on the control port
   localparam logic REG_FIRST_SYNC  = 1'b0;
   localparam logic REG_SECOND_SYNC = 1'b1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_SECOND  = 4'b0010,
      PH_COMMAND = 4'b0100,
      PH_CHECK   = 4'b1000
   } scfr_phase_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] command;
      logic              crc_ok;
   } scfr_result_type;

   // One byte through CRC-8, MSB first, no reflection
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (v[BYTE_W-1]) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== sv/scfr_parse.sv =====
// Frame phase machine with running CRC-8 and held command.
module scfr_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [scfr_pkg::BYTE_W-1:0] rx_byte,
   input  logic [scfr_pkg::BYTE_W-1:0] first_sync,
   input  logic [scfr_pkg::BYTE_W-1:0] second_sync,
   output scfr_pkg::scfr_result_type   result
);
   import scfr_pkg::*;

   scfr_phase_type    phase_ff, phase_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] crc_next;

   assign crc_next = crc8_step(crc_ff, rx_byte);

   always_comb begin
      phase_in       = phase_ff;
      crc_in         = crc_ff;
      cmd_in         = cmd_ff;
      result.valid   = 1'b0;
      result.command = cmd_ff;
      result.crc_ok  = (rx_byte == crc_ff);
      case (phase_ff)
         PH_HUNT: begin
            // crc is zero while hunting, so crc_next is the CRC of the sync byte
            if (rx_byte == first_sync) begin
               crc_in   = crc_next;
               phase_in = PH_SECOND;
            end else begin
               crc_in = '0;
            end
         end
         PH_SECOND: begin
            if (rx_byte == second_sync) begin
               crc_in   = crc_next;
               phase_in = PH_COMMAND;
            end else begin
               crc_in   = '0;
               phase_in = PH_HUNT;
            end
         end
         PH_COMMAND: begin
            cmd_in   = rx_byte;
            crc_in   = crc_next;
            phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            result.valid = 1'b1;
            crc_in       = '0;
            phase_in     = PH_HUNT;
         end
         default: begin
            crc_in   = '0;
            phase_in = PH_HUNT;
         end
      endcase
      if (!fire) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         crc_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== sv/sync_crc8_command_frame_receiver_top.sv =====
// Top level of the sync-word command frame receiver with CRC-8 check.
//
// The receiver takes one received byte per word on the req_ channel and looks
// for a frame: the first sync byte, the second sync byte, one command byte and
// one check byte. A CRC-8 (polynomial 0x07, initial value zero, MSB first, no
// reflection, no final xor) runs over both sync bytes and the command. On the
// check byte one word leaves on the rsp_ channel carrying the command and
// crc_ok, which is high when the check byte equals the CRC; the receiver then
// hunts again whether the CRC matched or not. A wrong second sync byte drops
// back to hunting and is itself discarded, even if it equals the first sync
// byte. Bytes seen while hunting that are not the first sync byte are ignored.
// Timing: a byte is accepted every clock while the output is free. Each byte
// is held in an input register, the phase machine and byte-wide CRC update
// run while it sits there, and a completed frame lands in the output register
// at the edge that moves the check byte on out of the input register. A result
// held by a stalled rsp_ side blocks input: the input register takes at most
// one more byte and holds it, with req_stall high, until the output word is
// taken. Sync bytes are set through the APB port: first_sync at 0x0 (reset
// 0xAA), second_sync at 0x4 (reset 0x55); write them only while the receiver
// is idle.
module sync_crc8_command_frame_receiver_top (
   input  logic                            clock,
   input  logic                            reset,
   // received bytes
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [scfr_pkg::BYTE_W-1:0]     req_rx_byte,
   // completed frames
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [scfr_pkg::BYTE_W-1:0]     rsp_command,
   output logic                            rsp_crc_ok,
   // control registers
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import scfr_pkg::*;

   // sync byte registers
   logic [BYTE_W-1:0] first_sync_ff, first_sync_in;
   logic [BYTE_W-1:0] second_sync_ff, second_sync_in;
   logic              csr_write;
   logic              csr_index;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_command_ff;
   logic              rsp_crc_ok_ff;

   logic              req_accept;
   logic              advance;
   scfr_result_type   result;

   // --- control port: zero wait states, index is the word address
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      first_sync_in  = first_sync_ff;
      second_sync_in = second_sync_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FIRST_SYNC:  first_sync_in  = csr_pwdata[BYTE_W-1:0];
            REG_SECOND_SYNC: second_sync_in = csr_pwdata[BYTE_W-1:0];
            default: begin
               first_sync_in = first_sync_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FIRST_SYNC:  csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, first_sync_ff};
         REG_SECOND_SYNC: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, second_sync_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= FIRST_SYNC_RST;
         second_sync_ff <= SECOND_SYNC_RST;
      end else begin
         first_sync_ff  <= first_sync_in;
         second_sync_ff <= second_sync_in;
      end
   end

   // --- byte flow: advance the input register whenever the output can take
   //     a word this edge (empty, or its word is being taken)
   assign advance    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   // --- phase machine and CRC; state moves only when the byte advances
   scfr_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .rx_byte     (s1_byte_ff),
      .first_sync  (first_sync_ff),
      .second_sync (second_sync_ff),
      .result      (result)
   );

   // --- output register: load on a finished frame, drop when taken, else hold
   always_comb begin
      if (advance) begin
         rsp_valid_in = result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_command_ff <= result.command;
         rsp_crc_ok_ff  <= result.crc_ok;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_crc_ok  = rsp_crc_ok_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the sync-word CRC-8 command frame receiver.
`timescale 1ns / 100ps

module tb_top;
   import scfr_pkg::*;

   // cycles to hold after the last expected frame so that trailing bytes drain
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_BYTES  = 1100;
   localparam int unsigned SEGMENTS      = 5;
   localparam int unsigned PRINT_CAP     = 40;

   typedef logic [BYTE_W-1:0] byte_type;

   // ways a random frame can be broken on purpose
   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_CHECK,
      FLAW_SECOND,
      FLAW_CUT
   } frame_flaw_type;

   typedef struct packed {
      byte_type command;
      logic     crc_ok;
   } frame_result_type;

   // clock, reset and the three ports; every input starts at a known value
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   byte_type              req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   byte_type              rsp_command;
   logic                  rsp_crc_ok;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // mirror of the receiver: sync settings, phase, CRC and held command
   byte_type       cfg_first  = FIRST_SYNC_RST;
   byte_type       cfg_second = SECOND_SYNC_RST;
   scfr_phase_type rx_phase   = PH_HUNT;
   byte_type       rx_crc     = '0;
   byte_type       rx_cmd     = '0;

   // frames predicted but not yet seen on the rsp_ side, oldest first
   frame_result_type pending_frames[$];

   int unsigned bytes_sent     = 0;
   int unsigned frames_checked = 0;
   int unsigned settings_tried = 0;
   int unsigned fault_count    = 0;

   // idle modes: when calm, that side never pauses
   logic req_calm    = 1'b0;
   logic stall_mode  = 1'b1;
   int unsigned stall_left = 0;

   sync_crc8_command_frame_receiver_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_command (rsp_command),
      .rsp_crc_ok  (rsp_crc_ok),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Feed the data bits in one at a time, MSB first; the feedback bit
   // selects whether the generator is folded in.
   function automatic byte_type crc8_next(input byte_type crc, input byte_type data);
      byte_type acc;
      logic     fb;
      acc = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb  = acc[BYTE_W-1] ^ data[i];
         acc = {acc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : byte_type'(0));
      end
      return acc;
   endfunction

   // Check byte that a sender would append to a well-formed frame.
   function automatic byte_type frame_check(input byte_type first, input byte_type second,
                                            input byte_type cmd);
      return crc8_next(crc8_next(crc8_next('0, first), second), cmd);
   endfunction

   // Advance the mirrored phase machine by one accepted word; queue the
   // frame it completes, if any.
   task automatic track_frame(input byte_type b);
      case (rx_phase)
         PH_HUNT: begin
            if (b == cfg_first) begin
               rx_crc   = crc8_next('0, b);
               rx_phase = PH_SECOND;
            end else begin
               rx_crc = '0;
            end
         end
         PH_SECOND: begin
            // a wrong second sync byte is dropped outright, even a first sync
            if (b == cfg_second) begin
               rx_crc   = crc8_next(rx_crc, b);
               rx_phase = PH_COMMAND;
            end else begin
               rx_crc   = '0;
               rx_phase = PH_HUNT;
            end
         end
         PH_COMMAND: begin
            rx_cmd   = b;
            rx_crc   = crc8_next(rx_crc, b);
            rx_phase = PH_CHECK;
         end
         default: begin
            pending_frames.push_back('{command: rx_cmd, crc_ok: (b == rx_crc)});
            rx_crc   = '0;
            rx_phase = PH_HUNT;
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fault_count++;
      if (fault_count <= PRINT_CAP) begin
         $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   // Compare every accepted rsp_ word against the oldest pending frame.
   always @(posedge clock) begin : check_frames
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("frame with none pending", 32'(0),
                            32'({rsp_command, rsp_crc_ok}));
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_command !== want.command) begin
               report_mismatch("command", 32'(want.command), 32'(rsp_command));
            end
            if (rsp_crc_ok !== want.crc_ok) begin
               report_mismatch("crc_ok", 32'(want.crc_ok), 32'(rsp_crc_ok));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Idling
   // ------------------------------------------------------------------

   // Random pause length; now and then a long one.
   function automatic int unsigned pick_run();
      if ($urandom_range(0, 6) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Stall the rsp_ side in random runs; flip between stalling and calm
   // stretches so that both occur throughout the run.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_mode && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_run();
         end
      end
      if ($urandom_range(0, 499) == 0) begin
         stall_mode <= !stall_mode;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one byte as a word on the req_ side. Valid is only lowered during
   // a gap, so back-to-back words keep it high across the edge.
   task automatic send_byte(input byte_type b);
      int unsigned gap;
      gap = 0;
      if (!req_calm && $urandom_range(0, 2) == 0) begin
         gap = pick_run();
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      track_frame(b);
   endtask

   // Hold the sender until every pending frame is back, then let trailing
   // bytes settle inside the receiver.
   task automatic drain_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input byte_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_FIRST_SYNC) begin
         cfg_first = value;
      end else begin
         cfg_second = value;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read a register back and compare with the mirrored setting.
   task automatic csr_expect(input logic idx);
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'((idx == REG_FIRST_SYNC) ? cfg_first : cfg_second);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         report_mismatch(idx == REG_FIRST_SYNC ? "first_sync readback" :
                         "second_sync readback", want, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain, load both sync bytes, and read them back.
   task automatic apply_sync(input byte_type first, input byte_type second);
      drain_frames();
      csr_write(REG_FIRST_SYNC, first);
      csr_write(REG_SECOND_SYNC, second);
      csr_expect(REG_FIRST_SYNC);
      csr_expect(REG_SECOND_SYNC);
      settings_tried++;
   endtask

   // Send one frame under the current sync bytes, broken as asked.
   task automatic send_frame(input byte_type cmd, input frame_flaw_type flaw);
      byte_type check_byte;
      byte_type wrong;
      check_byte = frame_check(cfg_first, cfg_second, cmd);
      send_byte(cfg_first);
      if (flaw == FLAW_SECOND) begin
         wrong = byte_type'($urandom);
         while (wrong == cfg_second) wrong = byte_type'($urandom);
         send_byte(wrong);
      end else begin
         send_byte(cfg_second);
      end
      // a cut frame stops after the sync bytes; what follows lands in its slots
      if (flaw != FLAW_CUT) begin
         send_byte(cmd);
         if (flaw == FLAW_CHECK) begin
            send_byte(check_byte ^ byte_type'($urandom_range(1, 255)));
         end else begin
            send_byte(check_byte);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Extremes and special cases under the reset sync bytes.
   task automatic test_directed_frames();
      // stray bytes while hunting are ignored
      send_byte(8'h00);
      send_byte(8'hFF);
      // good frames with the smallest and largest command
      send_frame(8'h00, FLAW_NONE);
      send_frame(8'hFF, FLAW_NONE);
      // bad check byte still yields a frame, flagged as failed
      send_frame(8'h3C, FLAW_CHECK);
      // a second first-sync in the second slot is dropped, then 0x55 is noise
      send_byte(cfg_first);
      send_byte(cfg_first);
      send_byte(cfg_second);
      // an arbitrary command after a wrong second sync
      send_frame(8'h80, FLAW_SECOND);
      send_frame(8'h7E, FLAW_NONE);
      drain_frames();
   endtask

   // Reset values, extreme and equal sync bytes, and a write mid-frame.
   task automatic test_sync_settings();
      byte_type cmd;
      csr_expect(REG_FIRST_SYNC);
      csr_expect(REG_SECOND_SYNC);
      for (int k = 0; k < 4; k++) begin
         case (k)
            0:       apply_sync(8'h00, 8'hFF);
            1:       apply_sync(8'hFF, 8'h00);
            2:       apply_sync(8'h5A, 8'h5A);
            default: apply_sync(8'h01, 8'h80);
         endcase
         repeat (3) send_frame(byte_type'($urandom), FLAW_NONE);
         send_frame(byte_type'($urandom), FLAW_CHECK);
      end
      // change the second sync byte between the two sync bytes of a frame
      drain_frames();
      send_byte(cfg_first);
      drain_frames();
      csr_write(REG_SECOND_SYNC, 8'hC3);
      csr_expect(REG_SECOND_SYNC);
      cmd = byte_type'($urandom);
      send_byte(8'hC3);
      send_byte(cmd);
      send_byte(frame_check(cfg_first, cfg_second, cmd));
      apply_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
   endtask

   // Mostly well-formed frames with random commands, plus broken frames and
   // noise, across several sync settings.
   task automatic test_random_traffic();
      int unsigned seg_start;
      int unsigned pick;
      logic        paused;
      paused = 1'b0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0:       apply_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
            2:       apply_sync(8'hFF, 8'h00);
            4:       apply_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
            default: apply_sync(byte_type'($urandom), byte_type'($urandom));
         endcase
         seg_start = bytes_sent;
         while (bytes_sent - seg_start < RANDOM_BYTES / SEGMENTS) begin
            if ($urandom_range(0, 39) == 0) begin
               req_calm = !req_calm;
            end
            // hold the sender once mid-segment until every frame is back
            if (seg == 2 && !paused && bytes_sent - seg_start > RANDOM_BYTES / 10) begin
               drain_frames();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               send_frame(byte_type'($urandom), FLAW_NONE);
            end else if (pick < 82) begin
               send_frame(byte_type'($urandom), FLAW_CHECK);
            end else if (pick < 88) begin
               send_frame(byte_type'($urandom), FLAW_SECOND);
            end else if (pick < 92) begin
               send_frame(byte_type'($urandom), FLAW_CUT);
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  send_byte(($urandom_range(0, 4) == 0) ? cfg_first : byte_type'($urandom));
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_sync_settings();
      test_random_traffic();
      drain_frames();
      $display("Sent %0d bytes, checked %0d frames under %0d sync settings.",
               bytes_sent, frames_checked, settings_tried);
      $display("Covered good, bad-CRC, wrong-sync, cut frames, noise and CSR readback.");
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Drop the run if the receiver hangs.
   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
